>>> sv/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types and constants for the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_IDX_W = $clog2(PAL_DEPTH);
	localparam int COORD_W   = 12;
	localparam int RUN_W     = 6;

	localparam logic [1:0] OP_PAL_WR  = 2'd0;
	localparam logic [1:0] OP_DATA    = 2'd1;
	localparam logic [1:0] OP_NEW_IMG = 2'd2;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_LINE     = 2'd2;
	localparam logic [1:0] REG_BG_ALPHA = 2'd3;

	localparam logic [7:0] RUN_MARK = 8'hC0;
	localparam logic [7:0] RUN_MASK = 8'h3F;

	typedef struct packed {
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
		logic [COORD_W-1:0] line_bytes;
		logic [7:0]         bg_alpha;
	} cfg_t;

	// pal_wr: palette write of rgba at index; otherwise emit index over x0..x_last
	typedef struct packed {
		logic               pal_wr;
		logic [7:0]         index;
		logic [31:0]        rgba;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x_last;
		logic [COORD_W-1:0] y;
		logic               done;
	} cmd_t;

endpackage

>>> sv/pcxd_front.sv
// ----------------------------------------------------------------------------
// pcxd_front
// Accepts input transactions, tracks run markers, column and row, and turns
// each byte into at most one command for the pixel engine.
// ----------------------------------------------------------------------------
module pcxd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  pcxd_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [47:0]     in_data,
	input  logic [1:0]      in_op,
	input  logic            q_full,
	output logic            q_push,
	output pcxd_pkg::cmd_t  q_cmd
);
	import pcxd_pkg::*;

	logic [COORD_W-1:0] column_q;
	logic [COORD_W-1:0] row_q;
	logic               run_pending_q;
	logic [RUN_W-1:0]   run_count_q;

	logic [7:0]         data_byte;
	logic               accept;
	logic               in_image;
	logic               is_mark;
	logic               emit_go;
	logic [COORD_W-1:0] span;
	logic [COORD_W:0]   x_end;
	logic               wrap;
	logic [COORD_W-1:0] row_n;
	logic [COORD_W-1:0] vis_end;
	logic               vis;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign data_byte = in_data[47:40];
	assign in_image  = row_q < cfg.height;
	assign is_mark   = (data_byte & RUN_MARK) == RUN_MARK;
	assign emit_go   = accept && (in_op == OP_DATA) && in_image &&
		(run_pending_q ? (run_count_q != '0) : !is_mark);

	assign span    = (cfg.width > cfg.line_bytes) ? cfg.width : cfg.line_bytes;
	assign x_end   = {1'b0, column_q} +
		(run_pending_q ? (COORD_W+1)'(run_count_q) : (COORD_W+1)'(1));
	assign wrap    = x_end >= {1'b0, span};
	assign row_n   = row_q + COORD_W'(1);
	assign vis_end = (x_end < {1'b0, cfg.width}) ? x_end[COORD_W-1:0] : cfg.width;
	assign vis     = column_q < cfg.width;

	assign q_push = (accept && (in_op == OP_PAL_WR)) || (emit_go && vis);

	always_comb begin
		q_cmd.pal_wr = (in_op == OP_PAL_WR);
		q_cmd.index  = (in_op == OP_PAL_WR) ? in_data[7:0] : data_byte;
		q_cmd.rgba   = {in_data[15:8], in_data[23:16], in_data[31:24], in_data[39:32]};
		q_cmd.x0     = column_q;
		q_cmd.x_last = vis_end - COORD_W'(1);
		q_cmd.y      = row_q;
		q_cmd.done   = wrap && (row_n >= cfg.height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			row_q         <= '0;
			run_pending_q <= 1'b0;
			run_count_q   <= '0;
		end else if (accept) begin
			unique case (in_op)
				OP_NEW_IMG: begin
					column_q      <= '0;
					row_q         <= '0;
					run_pending_q <= 1'b0;
					run_count_q   <= '0;
				end
				OP_DATA: begin
					if (in_image) begin
						if (run_pending_q) begin
							run_pending_q <= 1'b0;
							run_count_q   <= '0;
						end else if (is_mark) begin
							run_pending_q <= 1'b1;
							run_count_q   <= RUN_W'(data_byte & RUN_MASK);
						end
					end
					if (emit_go) begin
						if (wrap) begin
							column_q <= '0;
							row_q    <= row_n;
						end else begin
							column_q <= x_end[COORD_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> sv/pcxd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pcxd_cmd_fifo
// Four-entry command queue between the byte front end and the pixel engine.
// ----------------------------------------------------------------------------
module pcxd_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcxd_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output pcxd_pkg::cmd_t  pop_cmd,
	output logic            empty
);
	import pcxd_pkg::*;

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);

	cmd_t          mem_q [Depth];
	logic [PtrW:0] wr_ptr_q;
	logic [PtrW:0] rd_ptr_q;

	assign empty   = wr_ptr_q == rd_ptr_q;
	assign full    = (wr_ptr_q[PtrW-1:0] == rd_ptr_q[PtrW-1:0]) &&
		(wr_ptr_q[PtrW] != rd_ptr_q[PtrW]);
	assign pop_cmd = mem_q[rd_ptr_q[PtrW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q[PtrW-1:0]] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + (PtrW+1)'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + (PtrW+1)'(1);
			end
		end
	end

endmodule

>>> sv/pcxd_back.sv
// ----------------------------------------------------------------------------
// pcxd_back
// Pixel engine: owns the palette memory, executes palette writes and emits
// one RGBA pixel per cycle for each pixel command while the output is not stalled.
// ----------------------------------------------------------------------------
module pcxd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   bg_alpha,
	input  logic                         cmd_valid,
	input  pcxd_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [55:0]                  out_data,
	output logic                         out_last,
	output logic                         out_user
);
	import pcxd_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic [31:0]        pal_mem [PAL_DEPTH];
	logic [31:0]        rd_q;
	logic               state_q;
	cmd_t               cur_q;
	logic [COORD_W-1:0] x_q;
	logic               out_valid_q;
	logic [55:0]        out_data_q;
	logic               out_last_q;
	logic               out_user_q;

	logic               slot_free;
	logic               fire;
	logic               is_last;
	logic [7:0]         alpha;

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = (state_q == ST_EMIT) && slot_free;
	assign is_last   = x_q == cur_q.x_last;
	assign alpha     = (cur_q.index == '0) ? bg_alpha : rd_q[7:0];

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_user  = out_user_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (cmd.pal_wr) begin
				pal_mem[cmd.index[PAL_IDX_W-1:0]] <= cmd.rgba;
			end else begin
				rd_q <= pal_mem[cmd.index[PAL_IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.pal_wr) begin
			cur_q <= cmd;
			x_q   <= cmd.x0;
		end else if (fire) begin
			x_q <= x_q + COORD_W'(1);
		end
		if (fire) begin
			out_data_q <= {cur_q.y, x_q, alpha, rd_q[15:8], rd_q[23:16], rd_q[31:24]};
			out_last_q <= is_last;
			out_user_q <= is_last && cur_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && !cmd.pal_wr) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (fire && is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/pcx_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// 8-bit PCX run-length decoder with 256-entry RGBA palette lookup.
//
// Slave stream: tuser[1:0] selects palette write, compressed byte or new
// image; tdata carries the palette entry and the compressed byte. Master
// stream: one transaction per visible pixel, tlast on the last pixel of an
// input byte, tuser set on the pixel that completes the final row.
// Config channel: cfg_index picks width, height, line bytes or background
// alpha; write only while the block is idle.
// Throughput: markers and skipped bytes occupy only the front end; a palette
// write or a byte with visible pixels is queued for the pixel engine, which
// for a pixel byte does a palette read, then emits one pixel per cycle while
// the output is not stalled. A four-entry command queue lets the front keep
// taking bytes while a run drains. Reset clears position, pending run, queue
// and output; the palette keeps its contents and must be loaded before use.
// When the receiver stalls the output holds, the queue fills and tready drops.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pal_index, pal_red, pal_green, pal_blue, pal_alpha, data_byte
	input  logic [47:0] s_axis_tdata,
	// opcode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// red, green, blue, alpha, pixel_x, pixel_y
	output logic [55:0] m_axis_tdata,
	// run_last
	output logic        m_axis_tlast,
	// image_done
	output logic        m_axis_tuser
);
	import pcxd_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_full;
	logic q_pop;
	cmd_t q_pop_cmd;
	logic q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width      <= COORD_W'(1);
			cfg_q.height     <= COORD_W'(1);
			cfg_q.line_bytes <= COORD_W'(1);
			cfg_q.bg_alpha   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:    cfg_q.width      <= cfg_data;
				REG_HEIGHT:   cfg_q.height     <= cfg_data;
				REG_LINE:     cfg_q.line_bytes <= cfg_data;
				REG_BG_ALPHA: cfg_q.bg_alpha   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	pcxd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_op    (s_axis_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_push_cmd)
	);

	pcxd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_pop_cmd),
		.empty    (q_empty)
	);

	pcxd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bg_alpha  (cfg_q.bg_alpha),
		.cmd_valid (!q_empty),
		.cmd       (q_pop_cmd),
		.cmd_pop   (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (m_axis_tuser)
	);

endmodule
